// ===== hdl/salsa_pkg.sv =====
package salsa_pkg;

	localparam int WORD_BITS = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int DEFAULT_ROUND_COUNT = 20;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [BLOCK_WORDS-1:0][WORD_BITS-1:0] block_t;
	typedef logic [3:0][63:0] key_t;
	typedef logic [3:0][3:0] quad_idx_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_KEY_01 = 3'd0;
	localparam logic [2:0] CFG_KEY_23 = 3'd1;
	localparam logic [2:0] CFG_KEY_45 = 3'd2;
	localparam logic [2:0] CFG_KEY_67 = 3'd3;
	localparam logic [2:0] CFG_NONCE = 3'd4;

	// Keystream position: 16 means the block is used up
	localparam logic [4:0] POS_EMPTY = 5'd16;

	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	localparam int ROT_A = 7;
	localparam int ROT_B = 9;
	localparam int ROT_C = 13;
	localparam int ROT_D = 18;

	// Quarter-round word indexes {d, c, b, a}, one entry per quarter
	localparam quad_idx_t COL_IDX [4] = '{
		{4'd12, 4'd8, 4'd4, 4'd0},
		{4'd1, 4'd13, 4'd9, 4'd5},
		{4'd6, 4'd2, 4'd14, 4'd10},
		{4'd11, 4'd7, 4'd3, 4'd15}
	};
	localparam quad_idx_t ROW_IDX [4] = '{
		{4'd3, 4'd2, 4'd1, 4'd0},
		{4'd4, 4'd7, 4'd6, 4'd5},
		{4'd9, 4'd8, 4'd11, 4'd10},
		{4'd14, 4'd13, 4'd12, 4'd15}
	};

	typedef struct packed {
		word_t data;
		logic  restart;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] counter;
	} gen_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

	function automatic word_t rotl(word_t v, int n);
		return (v << n) | (v >> (WORD_BITS - n));
	endfunction

	function automatic block_t init_matrix(key_t key, logic [63:0] nonce, logic [63:0] cnt);
		block_t m;
		m[0] = SIGMA_0;
		m[1] = key[0][31:0];
		m[2] = key[0][63:32];
		m[3] = key[1][31:0];
		m[4] = key[1][63:32];
		m[5] = SIGMA_1;
		m[6] = nonce[31:0];
		m[7] = nonce[63:32];
		m[8] = cnt[31:0];
		m[9] = cnt[63:32];
		m[10] = SIGMA_2;
		m[11] = key[2][31:0];
		m[12] = key[2][63:32];
		m[13] = key[3][31:0];
		m[14] = key[3][63:32];
		m[15] = SIGMA_3;
		return m;
	endfunction

	// Half of a quarter round: phase 0 updates b then c, phase 1 updates d then a
	function automatic block_t quarter_half(block_t x, quad_idx_t idx, logic phase);
		block_t y;
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		y = x;
		a = x[idx[0]];
		b = x[idx[1]];
		c = x[idx[2]];
		d = x[idx[3]];
		if (!phase) begin
			b = b ^ rotl(a + d, ROT_A);
			c = c ^ rotl(b + a, ROT_B);
		end else begin
			d = d ^ rotl(c + b, ROT_C);
			a = a ^ rotl(d + c, ROT_D);
		end
		y[idx[0]] = a;
		y[idx[1]] = b;
		y[idx[2]] = c;
		y[idx[3]] = d;
		return y;
	endfunction

endpackage

// ===== hdl/salsa_queue.sv =====
module salsa_queue
	import salsa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_pop,
	output item_t out_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready = (count_q < CNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item = entry_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/salsa_block.sv =====
module salsa_block
	import salsa_pkg::*;
#(
	parameter int ROUND_COUNT = DEFAULT_ROUND_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gen_req_t    req,
	input  key_t        key,
	input  logic [63:0] nonce,
	output gen_stat_t   stat,
	output block_t      words
);

	localparam int ROUNDS = 2 * ((ROUND_COUNT + 1) / 2);
	localparam int RW = $clog2(ROUNDS);

	typedef enum logic [1:0] {
		G_IDLE,
		G_RUN,
		G_ADD
	} gen_state_t;

	gen_state_t  state_q;
	block_t      x_q;
	logic [63:0] cnt_q;
	logic [RW-1:0] round_q;
	logic        phase_q;
	logic        done_q;
	block_t      col_x;
	block_t      row_x;
	block_t      init_w;

	// Four quarters of a round touch disjoint words, so chaining them is parallel
	always_comb begin
		col_x = x_q;
		row_x = x_q;
		for (int q = 0; q < 4; q++) begin
			col_x = quarter_half(col_x, COL_IDX[q], phase_q);
			row_x = quarter_half(row_x, ROW_IDX[q], phase_q);
		end
	end

	assign init_w = init_matrix(key, nonce, cnt_q);
	assign words = x_q;
	assign stat.busy = (state_q != G_IDLE);
	assign stat.done = done_q;

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				if (req.start) begin
					x_q <= init_matrix(key, nonce, req.counter);
					cnt_q <= req.counter;
				end
			end
			G_RUN: begin
				x_q <= round_q[0] ? row_x : col_x;
			end
			G_ADD: begin
				for (int i = 0; i < BLOCK_WORDS; i++) begin
					x_q[i] <= x_q[i] + init_w[i];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			round_q <= '0;
			phase_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (req.start) begin
						round_q <= '0;
						phase_q <= 1'b0;
						state_q <= G_RUN;
					end
				end
				G_RUN: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						round_q <= round_q + 1'b1;
						if (round_q == RW'(ROUNDS - 1)) begin
							state_q <= G_ADD;
						end
					end
				end
				G_ADD: begin
					done_q <= 1'b1;
					state_q <= G_IDLE;
				end
				default: begin
					state_q <= G_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/salsa_back.sv =====
module salsa_back
	import salsa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  item_t     item,
	output logic      item_pop,
	output gen_req_t  req,
	input  gen_stat_t stat,
	input  block_t    words,
	output logic      out_valid,
	input  logic      out_ready,
	output word_t     out_word
);

	typedef enum logic {
		B_IDLE,
		B_WAIT
	} back_state_t;

	back_state_t state_q;
	logic [4:0]  pos_q;
	logic [63:0] cnt_q;
	word_t       data_q;
	word_t       out_word_q;
	logic        out_valid_q;
	logic        can_load;
	logic [4:0]  eff_pos;
	logic [63:0] eff_cnt;
	logic        need_gen;

	assign can_load = !out_valid_q || out_ready;
	assign item_pop = (state_q == B_IDLE) && item_valid && can_load;
	assign eff_pos = item.restart ? POS_EMPTY : pos_q;
	assign eff_cnt = item.restart ? 64'd0 : cnt_q;
	assign need_gen = (eff_pos >= POS_EMPTY);
	assign req.start = item_pop && need_gen;
	assign req.counter = eff_cnt;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pos_q <= POS_EMPTY;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (item_pop) begin
						if (need_gen) begin
							cnt_q <= eff_cnt + 64'd1;
							pos_q <= '0;
							state_q <= B_WAIT;
						end else begin
							out_valid_q <= 1'b1;
							pos_q <= eff_pos + 5'd1;
						end
					end
				end
				B_WAIT: begin
					if (stat.done) begin
						out_valid_q <= 1'b1;
						pos_q <= 5'd1;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && item_pop) begin
			data_q <= item.data;
			if (!need_gen) begin
				out_word_q <= item.data ^ words[eff_pos[3:0]];
			end
		end else if (state_q == B_WAIT && stat.done) begin
			out_word_q <= data_q ^ words[0];
		end
	end

endmodule

// ===== hdl/salsa20_keystream_xor.sv =====
// Salsa20 keystream XOR on 32-bit words.
// Input channel (in_valid/in_ready): one beat carries data_word and restart.
// Each input beat gives exactly one output beat (out_valid/out_ready) with
// cipher_word = data_word XOR the next keystream word, in order.
// restart = 1 zeroes the block counter and drops the current keystream block
// before its own word is handled; issue one after changing key or nonce.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..3 writes
// key word pairs, 4 writes the nonce, other indexes are ignored. Write only
// while the block is idle.
// A word that hits a live keystream block passes the input queue and is then
// loaded straight into the output register. A word that needs a fresh block
// passes the queue, then the generator runs all rounds (ROUND_COUNT rounded up
// to even) and its add step, and then the output register is loaded.
// Throughput is one word per cycle within a block while out_ready stays high;
// at each new block the iterative round unit holds words back until it is done.
// A two-entry input queue keeps accepting, until it is full, while the back end
// generates or while a finished word waits in the output register; a stalled
// receiver simply holds the output register and backs the queue up.
// Reset: counter 0, keystream block empty, key and nonce registers 0.
module salsa20_keystream_xor
	import salsa_pkg::*;
#(
	parameter int ROUND_COUNT = DEFAULT_ROUND_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] cipher_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	key_t        key_q;
	logic [63:0] nonce_q;
	item_t       in_item;
	item_t       q_item;
	logic        q_valid;
	logic        q_pop;
	gen_req_t    gen_req;
	gen_stat_t   gen_stat;
	block_t      ks_words;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			nonce_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_01: key_q[0] <= cfg_data;
				CFG_KEY_23: key_q[1] <= cfg_data;
				CFG_KEY_45: key_q[2] <= cfg_data;
				CFG_KEY_67: key_q[3] <= cfg_data;
				CFG_NONCE:  nonce_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: input queue
	assign in_item.data = data_word;
	assign in_item.restart = restart;

	salsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_item  (q_item)
	);

	// Back: sequencing, counter/position tracking, output register
	salsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.item_pop   (q_pop),
		.req        (gen_req),
		.stat       (gen_stat),
		.words      (ks_words),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (cipher_word)
	);

	// Iterative round unit, also holds the current keystream block
	salsa_block #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_block (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (gen_req),
		.key    (key_q),
		.nonce  (nonce_q),
		.stat   (gen_stat),
		.words  (ks_words)
	);

	// A new block is only requested from an idle generator
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		gen_req.start |-> !gen_stat.busy)
		else $error("block start while generator busy");

	// A start always puts the generator to work on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		gen_req.start |=> gen_stat.busy)
		else $error("block start not taken");

	// Done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		gen_stat.done |=> !gen_stat.done)
		else $error("done held over two cycles");

	// No word is popped while a block is being generated
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		gen_stat.busy |-> !q_pop)
		else $error("item taken during block generation");

endmodule

// ===== dv/tb_salsa20_keystream_xor.sv =====
`timescale 1ns / 100ps

module tb_salsa20_keystream_xor;
	import salsa_pkg::*;

	localparam int ROUNDS = DEFAULT_ROUND_COUNT;
	// Cycles with no beat on any channel before the run is declared hung.
	// Worst legit gap is one block generation plus a long random stall on
	// either side; this is many times that.
	localparam int HANG_LIMIT = 3000;
	// Settle time after the last result before a register write or the end
	localparam int SETTLE_CYCLES = 6;
	localparam int WORDS_PER_PHASE = 467;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] data_word;
	logic        restart;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] cipher_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// Shadow copy of the block's registers and keystream state
	logic [63:0] key_reg [4];
	logic [63:0] nonce_reg;
	logic [63:0] blk_ctr;
	block_t      ks_block;
	logic [4:0]  ks_pos;

	word_t pending_cipher [$];
	word_t want_word;
	int    err_count;
	int    idle_pct;
	int    stall_pct;
	int    quiet_cycles;

	salsa20_keystream_xor #(
		.ROUND_COUNT(ROUNDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_word(data_word),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cipher_word(cipher_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Keystream predictor
	// ---------------------------------------------------------------
	function automatic word_t rol32(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// One quarter round on words a, b, c, d of the matrix
	function automatic block_t mix_quarter(block_t x, int a, int b, int c, int d);
		x[b] = x[b] ^ rol32(x[a] + x[d], ROT_A);
		x[c] = x[c] ^ rol32(x[b] + x[a], ROT_B);
		x[d] = x[d] ^ rol32(x[c] + x[b], ROT_C);
		x[a] = x[a] ^ rol32(x[d] + x[c], ROT_D);
		return x;
	endfunction

	// Build the matrix from the shadow key/nonce/counter, run the double
	// rounds (odd counts round up), then add the start matrix back in.
	function automatic block_t gen_keystream_block();
		block_t init;
		block_t x;
		init[0]  = SIGMA_0;
		init[1]  = key_reg[0][31:0];
		init[2]  = key_reg[0][63:32];
		init[3]  = key_reg[1][31:0];
		init[4]  = key_reg[1][63:32];
		init[5]  = SIGMA_1;
		init[6]  = nonce_reg[31:0];
		init[7]  = nonce_reg[63:32];
		init[8]  = blk_ctr[31:0];
		init[9]  = blk_ctr[63:32];
		init[10] = SIGMA_2;
		init[11] = key_reg[2][31:0];
		init[12] = key_reg[2][63:32];
		init[13] = key_reg[3][31:0];
		init[14] = key_reg[3][63:32];
		init[15] = SIGMA_3;
		x = init;
		for (int r = 0; r < ROUNDS; r += 2) begin
			// column round
			x = mix_quarter(x, 0, 4, 8, 12);
			x = mix_quarter(x, 5, 9, 13, 1);
			x = mix_quarter(x, 10, 14, 2, 6);
			x = mix_quarter(x, 15, 3, 7, 11);
			// row round
			x = mix_quarter(x, 0, 1, 2, 3);
			x = mix_quarter(x, 5, 6, 7, 4);
			x = mix_quarter(x, 10, 11, 8, 9);
			x = mix_quarter(x, 15, 12, 13, 14);
		end
		for (int i = 0; i < BLOCK_WORDS; i++)
			x[i] = x[i] + init[i];
		return x;
	endfunction

	// Advance the shadow state by one input word, return its cipher word
	function automatic word_t predict_cipher(word_t data, logic rst);
		word_t ks;
		if (rst) begin
			blk_ctr = '0;
			ks_pos = POS_EMPTY;
		end
		// empty or used-up block: make a fresh one, counter wraps mod 2^64
		if (ks_pos >= BLOCK_WORDS) begin
			ks_block = gen_keystream_block();
			blk_ctr = blk_ctr + 64'd1;
			ks_pos = '0;
		end
		ks = ks_block[ks_pos[3:0]];
		ks_pos = ks_pos + 5'd1;
		return data ^ ks;
	endfunction

	// ---------------------------------------------------------------
	// Monitors and checker, all sampled at the rising edge
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input word_t exp_w, input word_t got_w);
		$display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_w, got_w);
		err_count++;
	endtask

	// Register beats update the shadow copy; out-of-list indexes are dropped
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_01: key_reg[0] = cfg_data;
				CFG_KEY_23: key_reg[1] = cfg_data;
				CFG_KEY_45: key_reg[2] = cfg_data;
				CFG_KEY_67: key_reg[3] = cfg_data;
				CFG_NONCE:  nonce_reg = cfg_data;
				default: ;
			endcase
		end
	end

	// Each accepted input beat queues exactly one expected cipher word
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			pending_cipher.push_back(predict_cipher(data_word, restart));
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_cipher.size() == 0) begin
				report_mismatch("unexpected beat", '0, cipher_word);
			end else begin
				want_word = pending_cipher.pop_front();
				if (cipher_word !== want_word)
					report_mismatch("cipher_word", want_word, cipher_word);
			end
		end
	end

	// Hang detector: counts cycles in which no channel moves a beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t hang: no beat for %0d cycles", $realtime, quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Receiver: random backpressure at the rate of the current phase
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ---------------------------------------------------------------
	// Drivers, all changing at the falling edge
	// ---------------------------------------------------------------
	// Send one data beat; random idle cycles go in front of it. When no
	// idle is drawn, valid stays high and only the payload changes.
	task automatic send_word(input word_t data, input logic rst);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		data_word <= data;
		restart   <= rst;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait until every queued word has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_cipher.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_all_regs(input logic [63:0] val);
		write_reg(CFG_KEY_01, val);
		write_reg(CFG_KEY_23, val);
		write_reg(CFG_KEY_45, val);
		write_reg(CFG_KEY_67, val);
		write_reg(CFG_NONCE, val);
	endtask

	// Mostly random, with a fair share of all-zero and all-one values
	function automatic logic [63:0] pick_reg_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return {32'h0, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Zero key and nonce out of reset; the block starts empty, so the very
	// first word makes block 0 even without a restart.
	task automatic test_reset_state();
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hffff_ffff, 1'b0);
		send_word(32'ha5a5_a5a5, 1'b0);
		wait_drained();
	endtask

	// All-one key and nonce, then back to all-zero
	task automatic test_register_extremes();
		write_all_regs('1);
		send_word(32'h5a5a_5a5a, 1'b1);
		send_word(32'hffff_ffff, 1'b0);
		wait_drained();
		write_all_regs('0);
		send_word(32'h0000_0000, 1'b1);
		wait_drained();
	endtask

	// A key change keeps the live block in use until a restart
	task automatic test_live_block_rewrite();
		write_reg(CFG_KEY_01, 64'h0123_4567_89ab_cdef);
		send_word(32'h1357_9bdf, 1'b1);
		wait_drained();
		write_reg(CFG_KEY_67, 64'hfedc_ba98_7654_3210);
		write_reg(CFG_NONCE, 64'h8000_0000_0000_0001);
		send_word(32'h2468_ace0, 1'b0);
		send_word(32'h0f0f_0f0f, 1'b1);
		wait_drained();
	endtask

	// Indexes past the nonce must not touch any register
	task automatic test_ignored_index();
		write_reg(3'd5, '1);
		write_reg(3'd6, 64'hdead_beef_cafe_f00d);
		write_reg(3'd7, '1);
		send_word(32'hf0f0_f0f0, 1'b1);
		wait_drained();
	endtask

	// Run past the end of a block into the next counter value
	task automatic test_block_crossing();
		for (int i = 0; i < BLOCK_WORDS + 1; i++)
			send_word($urandom(), (i == 0));
		wait_drained();
	endtask

	// Random segments: reprogram while idle, then a burst of words that
	// usually opens with a restart. Some segments skip the restart or
	// throw one in mid-burst to keep the old block / counter in play.
	task automatic run_random_phase(input int n_words, input int idle, input int stall);
		int sent;
		int seg_len;
		sent = 0;
		idle_pct = idle;
		stall_pct = stall;
		while (sent < n_words) begin
			wait_drained();
			if ($urandom_range(3) != 0) begin
				for (int r = 0; r < 5; r++)
					if ($urandom_range(4) != 0)
						write_reg(r[2:0], pick_reg_value());
				if ($urandom_range(7) == 0)
					write_reg(3'($urandom_range(5, 7)), pick_reg_value());
			end
			seg_len = ($urandom_range(7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 33);
			for (int i = 0; i < seg_len; i++) begin
				if (i == 0)
					send_word($urandom(), ($urandom_range(9) != 0));
				else
					send_word($urandom(), ($urandom_range(39) == 0));
			end
			sent += seg_len;
		end
		wait_drained();
	endtask

	task automatic test_random();
		run_random_phase(WORDS_PER_PHASE, 0, 0);
		run_random_phase(WORDS_PER_PHASE, 64, 0);
		run_random_phase(WORDS_PER_PHASE, 0, 64);
		run_random_phase(WORDS_PER_PHASE, 19, 19);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_word    = '0;
		restart      = 1'b0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		err_count    = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		quiet_cycles = 0;
		// shadow state matches the block after reset
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		nonce_reg = '0;
		blk_ctr   = '0;
		ks_block  = '0;
		ks_pos    = POS_EMPTY;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_register_extremes();
		test_live_block_rewrite();
		test_ignored_index();
		test_block_crossing();
		test_random();

		wait_drained();
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
